>>> hw/rtl/fdr_pkg.sv
// Shared types and constants for the dielectric Fresnel reflectance pipeline.
`timescale 1ns / 1ps
package fdr_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 17;
   localparam int DIV_W      = 50;

   localparam logic [16:0] FRAC_ONE = 17'h10000;
   localparam logic [15:0] REFL_MAX = 16'hFFFF;

   // per-item values that travel alongside the square root
   typedef struct packed {
      logic [16:0] ci;
      logic [15:0] ei;
      logic [31:0] eo2;
      logic        tir;
   } fdr_side_type;

endpackage

>>> hw/rtl/fdr_front.sv
// Front end: dot product, cos_i clamp, total internal reflection test and radicand.
`timescale 1ns / 1ps
module fdr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [15:0]   dir_x,
   input  logic signed [15:0]   dir_y,
   input  logic signed [15:0]   dir_z,
   input  logic signed [15:0]   norm_x,
   input  logic signed [15:0]   norm_y,
   input  logic signed [15:0]   norm_z,
   input  logic [15:0]          eta_in,
   input  logic [15:0]          eta_out,
   output logic                 out_valid,
   output fdr_pkg::fdr_side_type side,
   output logic [63:0]          rad
);
   import fdr_pkg::*;

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [15:0]        ei1_ff, ei2_ff, ei3_ff, ei4_ff, ei5_ff;
   logic [31:0]        eisq1_ff, eisq2_ff, eisq3_ff;
   logic [31:0]        eo2a_ff, eo2b_ff, eo2c_ff, eo2d_ff, eo2e_ff;
   logic [16:0]        ci2_ff, ci3_ff, ci4_ff, ci5_ff;
   logic [32:0]        om3_ff;
   logic [63:0]        lhs4_ff, rhs4_ff;
   logic               tir5_ff;
   logic [63:0]        rad5_ff;

   logic signed [33:0] dot_in;
   logic [33:0]        mag_in;
   logic [16:0]        ci_in;
   logic [33:0]        cisq_in;
   logic [32:0]        om_in;
   logic [64:0]        lhs_in;
   logic               tir_in;

   always_comb begin
      dot_in = 34'(px_ff) + 34'(py_ff) + 34'(pz_ff);
      mag_in = dot_in[33] ? 34'(-dot_in) : 34'(dot_in);
      if (mag_in > 34'h1000_0000) begin
         ci_in = FRAC_ONE;
      end else begin
         ci_in = mag_in[28:12];
      end
      cisq_in = 34'(ci2_ff) * 34'(ci2_ff);
      om_in   = 33'(34'h1_0000_0000 - cisq_in);
      lhs_in  = 65'(eisq3_ff) * 65'(om3_ff);
      tir_in  = lhs4_ff >= rhs4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff    <= dir_x * norm_x;
         py_ff    <= dir_y * norm_y;
         pz_ff    <= dir_z * norm_z;
         ei1_ff   <= eta_in;
         eisq1_ff <= 32'(eta_in) * 32'(eta_in);
         eo2a_ff  <= 32'(eta_out) * 32'(eta_out);

         ci2_ff   <= ci_in;
         ei2_ff   <= ei1_ff;
         eisq2_ff <= eisq1_ff;
         eo2b_ff  <= eo2a_ff;

         om3_ff   <= om_in;
         ci3_ff   <= ci2_ff;
         ei3_ff   <= ei2_ff;
         eisq3_ff <= eisq2_ff;
         eo2c_ff  <= eo2b_ff;

         lhs4_ff  <= lhs_in[63:0];
         rhs4_ff  <= {eo2c_ff, 32'h0};
         ci4_ff   <= ci3_ff;
         ei4_ff   <= ei3_ff;
         eo2d_ff  <= eo2c_ff;

         tir5_ff  <= tir_in;
         rad5_ff  <= tir_in ? 64'h0 : rhs4_ff - lhs4_ff;
         ci5_ff   <= ci4_ff;
         ei5_ff   <= ei4_ff;
         eo2e_ff  <= eo2d_ff;
      end
   end

   assign out_valid = v5_ff;
   assign rad       = rad5_ff;
   assign side      = '{ci: ci5_ff, ei: ei5_ff, eo2: eo2e_ff, tir: tir5_ff};

endmodule

>>> hw/rtl/fdr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module fdr_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  fdr_pkg::fdr_side_type in_side,
   input  logic [63:0]           rad,
   output logic                  out_valid,
   output fdr_pkg::fdr_side_type out_side,
   output logic [31:0]           root
);
   import fdr_pkg::*;

   logic         valid_ff [0:SQRT_STEPS];
   fdr_side_type side_ff  [0:SQRT_STEPS];
   logic [63:0]  x_ff     [0:SQRT_STEPS];
   logic [35:0]  rem_ff   [0:SQRT_STEPS];
   logic [31:0]  root_ff  [0:SQRT_STEPS];

   assign valid_ff[0] = in_valid;
   assign side_ff[0]  = in_side;
   assign x_ff[0]     = rad;
   assign rem_ff[0]   = 36'h0;
   assign root_ff[0]  = 32'h0;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      logic [35:0] cur_in;
      logic [35:0] trial_in;
      logic        take_in;

      always_comb begin
         cur_in   = {rem_ff[i][33:0], x_ff[i][63:62]};
         trial_in = {2'b00, root_ff[i], 2'b01};
         take_in  = cur_in >= trial_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i+1] <= side_ff[i];
            x_ff[i+1]    <= {x_ff[i][61:0], 2'b00};
            rem_ff[i+1]  <= take_in ? cur_in - trial_in : cur_in;
            root_ff[i+1] <= {root_ff[i][30:0], take_in};
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS];
   assign out_side  = side_ff[SQRT_STEPS];
   assign root      = root_ff[SQRT_STEPS];

endmodule

>>> hw/rtl/fdr_div.sv
// Pipelined fraction divider: floor(n * 2^16 / d) for n <= d, one quotient bit per stage.
`timescale 1ns / 1ps
module fdr_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [fdr_pkg::DIV_W-1:0]  num,
   input  logic [fdr_pkg::DIV_W-1:0]  den,
   output logic [16:0]                quo
);
   import fdr_pkg::*;

   logic [DIV_W:0]   r_ff [0:DIV_STEPS];
   logic [DIV_W-1:0] d_ff [0:DIV_STEPS];
   logic [16:0]      q_ff [0:DIV_STEPS];

   assign r_ff[0] = {1'b0, num};
   assign d_ff[0] = den;
   assign q_ff[0] = 17'h0;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [DIV_W:0] sh_in;
      logic           ge_in;

      always_comb begin
         if (i == 0) begin
            sh_in = r_ff[i];
         end else begin
            sh_in = {r_ff[i][DIV_W-1:0], 1'b0};
         end
         ge_in = sh_in >= {1'b0, d_ff[i]};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[i+1] <= ge_in ? sh_in - {1'b0, d_ff[i]} : sh_in;
            d_ff[i+1] <= d_ff[i];
            q_ff[i+1] <= {q_ff[i][15:0], ge_in};
         end
      end
   end

   assign quo = q_ff[DIV_STEPS];

endmodule

>>> hw/rtl/fdr_ratio.sv
// Back end: s and p amplitude ratios, their squares and the saturated mean.
`timescale 1ns / 1ps
module fdr_ratio (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  fdr_pkg::fdr_side_type side,
   input  logic [31:0]           root,
   output logic                  out_valid,
   output logic [15:0]           reflectance,
   output logic                  total_internal
);
   import fdr_pkg::*;

   logic        va_ff, vb_ff, vc_ff, vd_ff;
   logic        tira_ff, tirb_ff, tirc_ff, tird_ff;
   logic [32:0] t1_ff;
   logic [48:0] p1_ff;
   logic [47:0] p2_ff;
   logic [31:0] a_ff;
   logic [DIV_W-1:0] ns_ff, ds_ff, np_ff, dp_ff;
   logic        dpz_ff;
   logic        vl_ff   [0:DIV_STEPS];
   logic        tirl_ff [0:DIV_STEPS];
   logic        dpzl_ff [0:DIV_STEPS];
   logic [33:0] sqs_ff, sqp_ff;
   logic [15:0] refl_ff;

   logic [16:0] qs, qp, qp_in;
   logic [33:0] ds_in;
   logic [49:0] dp_in;
   logic [34:0] sum_in;

   fdr_div u_div_s (.clock(clock), .en(en), .num(ns_ff), .den(ds_ff), .quo(qs));
   fdr_div u_div_p (.clock(clock), .en(en), .num(np_ff), .den(dp_ff), .quo(qp));

   assign vl_ff[0]   = vb_ff;
   assign tirl_ff[0] = tirb_ff;
   assign dpzl_ff[0] = dpz_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_line
      always_ff @(posedge clock) begin
         if (reset) begin
            vl_ff[i+1] <= 1'b0;
         end else if (en) begin
            vl_ff[i+1] <= vl_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            tirl_ff[i+1] <= tirl_ff[i];
            dpzl_ff[i+1] <= dpzl_ff[i];
         end
      end
   end

   always_comb begin
      ds_in  = 34'(t1_ff) + 34'(a_ff);
      dp_in  = 50'(p1_ff) + 50'(p2_ff);
      qp_in  = dpzl_ff[DIV_STEPS] ? FRAC_ONE : qp;
      sum_in = 35'(sqs_ff) + 35'(sqp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vl_ff[DIV_STEPS];
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff   <= 33'(side.ei) * 33'(side.ci);
         p1_ff   <= 49'(side.eo2) * 49'(side.ci);
         p2_ff   <= 48'(side.ei) * 48'(root);
         a_ff    <= root;
         tira_ff <= side.tir;

         ds_ff   <= DIV_W'(ds_in);
         ns_ff   <= DIV_W'((33'(t1_ff) >= 33'(a_ff)) ? 33'(t1_ff) - 33'(a_ff)
                                                     : 33'(a_ff) - 33'(t1_ff));
         dp_ff   <= dp_in;
         np_ff   <= DIV_W'((49'(p1_ff) >= 49'(p2_ff)) ? 49'(p1_ff) - 49'(p2_ff)
                                                     : 49'(p2_ff) - 49'(p1_ff));
         dpz_ff  <= dp_in == 50'h0;
         tirb_ff <= tira_ff;

         sqs_ff  <= 34'(qs) * 34'(qs);
         sqp_ff  <= 34'(qp_in) * 34'(qp_in);
         tirc_ff <= tirl_ff[DIV_STEPS];

         tird_ff <= tirc_ff;
         if (tirc_ff || sum_in[34:17] > 18'(REFL_MAX)) begin
            refl_ff <= REFL_MAX;
         end else begin
            refl_ff <= sum_in[32:17];
         end
      end
   end

   assign out_valid      = vd_ff;
   assign reflectance    = refl_ff;
   assign total_internal = tird_ff;

endmodule

>>> hw/rtl/fresnel_dielectric_reflectance.sv
// Top level of the exact unpolarized dielectric Fresnel reflectance pipeline.
`timescale 1ns / 1ps
// Takes one ray/normal/index item per clock unless the output stalls, and returns one
// reflectance item per item, in order, after the front end, the 32-stage square root and
// the 17-stage fraction dividers; the pipeline holds as a whole while the output item is
// not taken, so req_tready equals !rsp_tvalid || rsp_tready.
module fresnel_dielectric_reflectance (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_in, eta_out (16 bits each)
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // reflectance
   output logic [15:0]  rsp_tdata,
   // total_internal
   output logic         rsp_tuser
);
   import fdr_pkg::*;

   logic         en;
   logic         f_valid, s_valid;
   fdr_side_type f_side, s_side;
   logic [63:0]  rad;
   logic [31:0]  root;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   fdr_front u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_tvalid),
      .dir_x(req_tdata[15:0]),    .dir_y(req_tdata[31:16]),  .dir_z(req_tdata[47:32]),
      .norm_x(req_tdata[63:48]),  .norm_y(req_tdata[79:64]), .norm_z(req_tdata[95:80]),
      .eta_in(req_tdata[111:96]), .eta_out(req_tdata[127:112]),
      .out_valid(f_valid), .side(f_side), .rad(rad)
   );

   fdr_sqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(f_valid), .in_side(f_side),
      .rad(rad), .out_valid(s_valid), .out_side(s_side), .root(root)
   );

   fdr_ratio u_ratio (
      .clock(clock), .reset(reset), .en(en), .in_valid(s_valid), .side(s_side),
      .root(root), .out_valid(rsp_tvalid), .reflectance(rsp_tdata),
      .total_internal(rsp_tuser)
   );

   a_tir_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == REFL_MAX)
      else $error("total internal reflection item without full reflectance");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output item present straight after reset");

endmodule
